// ----- design/rhm_pkg.sv -----
// ----------------------------------------------------------------------------
// rhm_pkg
// Shared widths, codes and request types for the range histogram block.
// ----------------------------------------------------------------------------
package rhm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int NUM_BINS    = 64;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);
  localparam int BINS_W      = $clog2(NUM_BINS + 1);
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 48;
  localparam int FRAC_BITS   = 8;
  localparam int MEAN_W      = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Bin index dividend is (sample - low) * bins; the mean dividend is |sum| << 8.
  localparam int PROD_W = SAMPLE_BITS + BINS_W;
  localparam int DIV_W  = SUM_W + FRAC_BITS;
  localparam int DVS_W  = CNT_W;
  localparam int ITER_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_BOUND  = 2'd0,
    CFG_HIGH_BOUND = 2'd1,
    CFG_BINS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIN_START,
    ST_BIN_DIV,
    ST_BIN_RD,
    ST_BIN_WR,
    ST_MEAN_START,
    ST_MEAN_DIV,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 clear;
    logic [BIN_IDX_W-1:0] addr;
    logic [CNT_W-1:0]     wr_data;
  } mem_req_t;

endpackage

// ----- design/rhm_in_if.sv -----
// ----------------------------------------------------------------------------
// rhm_in_if
// Request channel carrying one histogram action.
// ----------------------------------------------------------------------------
interface rhm_in_if;
  import rhm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [BIN_IDX_W-1:0]          bin_index;

  modport source (output valid, output action, output sample, output bin_index,
                  input ready);
  modport sink   (input valid, input action, input sample, input bin_index,
                  output ready);
endinterface

// ----- design/rhm_out_if.sv -----
// ----------------------------------------------------------------------------
// rhm_out_if
// Result channel carrying the status of one completed request.
// ----------------------------------------------------------------------------
interface rhm_out_if;
  import rhm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     sample_accepted;
  logic [BINS_W-1:0]        bin_hit;
  logic [CNT_W-1:0]         bin_count_value;
  logic [CNT_W-1:0]         samples_in_range;
  logic [CNT_W-1:0]         samples_out_of_range;
  logic signed [MEAN_W-1:0] mean_value;

  modport source (output valid, output sample_accepted, output bin_hit,
                  output bin_count_value, output samples_in_range,
                  output samples_out_of_range, output mean_value, input ready);
  modport sink   (input valid, input sample_accepted, input bin_hit,
                  input bin_count_value, input samples_in_range,
                  input samples_out_of_range, input mean_value, output ready);
endinterface

// ----- design/rhm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rhm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rhm_cfg_if;
  import rhm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/rhm_divider.sv -----
// ----------------------------------------------------------------------------
// rhm_divider
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rhm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rhm_pkg::div_req_t req,
  output rhm_pkg::div_rsp_t rsp
);
  import rhm_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;
  logic              ge;

  // The caller left-aligns the dividend, so only the top iters bits are
  // walked and the quotient lands in the low bits of quo_r.
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = !trial[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- design/rhm_bin_store.sv -----
// ----------------------------------------------------------------------------
// rhm_bin_store
// Bin count memory with one valid bit per bin, so a clear empties every bin at once.
// ----------------------------------------------------------------------------
module rhm_bin_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rhm_pkg::mem_req_t        req,
  output logic [rhm_pkg::CNT_W-1:0] rd_data
);
  import rhm_pkg::*;

  logic [CNT_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [CNT_W-1:0]    rd_mem_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_mem_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  // A bin never written since reset or the last clear reads as zero.
  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

// ----- design/range_histogram_with_mean.sv -----
// ----------------------------------------------------------------------------
// range_histogram_with_mean
// Histogram of signed samples over a programmable range, with running mean.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: add a sample, read one bin count, or clear
//   the histogram. out_ch returns exactly one result per request with the
//   add status, the bin read, both sample counters and the mean in Q15.8.
//   cfg_ch writes low_bound, high_bound and bins_in_use; it is always ready
//   and is meant to be written only while no request is in flight.
// Timing:
//   One request is worked at a time. An in-range add runs the shared radix-2
//   divider twice, once for the bin index (23 quotient bits) and once for
//   the mean (56 quotient bits); a zero-width range skips the first division.
//   An out-of-range add, a clear or an unknown action goes straight to
//   ST_DONE; a read first waits in ST_READ_WAIT for the bin store.
//   The divider sets the rate of in-range adds.
// Reset:
//   rst_n clears the counters, the sum, the mean and all bins (through their
//   valid bits), and sets the range to 0..0 with one bin. No clearing pass.
// Backpressure:
//   A finished result sits in the output register; the next request is taken
//   meanwhile and only its completion waits for out_ch.ready.
// ----------------------------------------------------------------------------
module range_histogram_with_mean (
  input logic       clk,
  input logic       rst_n,
  rhm_in_if.sink    in_ch,
  rhm_out_if.source out_ch,
  rhm_cfg_if.sink   cfg_ch
);
  import rhm_pkg::*;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] low_r;
  logic signed [SAMPLE_BITS-1:0] high_r;
  logic [BINS_W-1:0]             bins_r;

  logic [CNT_W-1:0]        in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [MEAN_W-1:0]       mean_r, mean_nxt;
  logic [SAMPLE_BITS-1:0]  diff_r, diff_nxt;
  logic [SAMPLE_BITS-1:0]  range_r, range_nxt;
  logic [BINS_W-1:0]       ix_r, ix_nxt;
  logic [BIN_IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                    res_acc_r, res_acc_nxt;
  logic [BINS_W-1:0]       res_hit_r, res_hit_nxt;
  logic [CNT_W-1:0]        res_read_r, res_read_nxt;

  logic                    out_vld_r, out_vld_nxt;
  logic                    out_load;
  logic                    out_acc_r;
  logic [BINS_W-1:0]       out_hit_r;
  logic [CNT_W-1:0]        out_read_r;
  logic [CNT_W-1:0]        out_in_cnt_r;
  logic [CNT_W-1:0]        out_out_cnt_r;
  logic [MEAN_W-1:0]       out_mean_r;

  logic [BINS_W-1:0]         nb_w;
  logic                      in_acc;
  logic                      in_range_w;
  logic signed [SAMPLE_BITS:0] diff_w;
  logic signed [SAMPLE_BITS:0] range_w;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          sum_sat;
  logic [SUM_W-1:0]          sum_mag;
  logic [PROD_W-1:0]         prod_w;
  logic [DIV_W-1:0]          quo_w;
  logic [CNT_W-1:0]          mem_rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mem_req_t mem_req;

  rhm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rhm_bin_store u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
      bins_r <= BINS_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LOW_BOUND:  low_r  <= cfg_ch.data[SAMPLE_BITS-1:0];
        CFG_HIGH_BOUND: high_r <= cfg_ch.data[SAMPLE_BITS-1:0];
        CFG_BINS:       bins_r <= cfg_ch.data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bin count: zero acts as one, anything above the store size clamps.
  always_comb begin
    if (bins_r == '0) begin
      nb_w = BINS_W'(1);
    end else if (bins_r > BINS_W'(NUM_BINS)) begin
      nb_w = BINS_W'(NUM_BINS);
    end else begin
      nb_w = bins_r;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_range_w = (in_ch.sample >= low_r) && (in_ch.sample <= high_r);
  assign diff_w     = {in_ch.sample[SAMPLE_BITS-1], in_ch.sample}
                    - {low_r[SAMPLE_BITS-1], low_r};
  assign range_w    = {high_r[SAMPLE_BITS-1], high_r} - {low_r[SAMPLE_BITS-1], low_r};

  // Saturating 48-bit accumulate of the sample.
  assign sum_ext = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(in_ch.sample);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign sum_mag = sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;
  assign prod_w  = PROD_W'(diff_r) * PROD_W'(nb_w);
  assign quo_w   = div_rsp.quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      sum_r     <= '0;
      mean_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      sum_r     <= sum_nxt;
      mean_r    <= mean_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    range_r    <= range_nxt;
    ix_r       <= ix_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_acc_r  <= res_acc_nxt;
    res_hit_r  <= res_hit_nxt;
    res_read_r <= res_read_nxt;
    if (out_load) begin
      out_acc_r     <= res_acc_r;
      out_hit_r     <= res_hit_r;
      out_read_r    <= res_read_r;
      out_in_cnt_r  <= in_cnt_r;
      out_out_cnt_r <= out_cnt_r;
      out_mean_r    <= mean_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_cnt_nxt   = in_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    sum_nxt      = sum_r;
    mean_nxt     = mean_r;
    diff_nxt     = diff_r;
    range_nxt    = range_r;
    ix_nxt       = ix_r;
    rd_idx_nxt   = rd_idx_r;
    res_acc_nxt  = res_acc_r;
    res_hit_nxt  = res_hit_r;
    res_read_nxt = res_read_r;
    out_load     = 1'b0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;

    div_req.start    = 1'b0;
    div_req.iters    = ITER_W'(DIV_W);
    div_req.dividend = {sum_mag, FRAC_BITS'(0)};
    div_req.divisor  = in_cnt_r;

    mem_req.rd_en   = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.clear   = 1'b0;
    mem_req.addr    = ix_r[BIN_IDX_W-1:0];
    mem_req.wr_data = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + CNT_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_acc_nxt  = 1'b0;
          res_hit_nxt  = BINS_W'(NUM_BINS);
          res_read_nxt = '0;
          rd_idx_nxt   = in_ch.bin_index;
          diff_nxt     = diff_w[SAMPLE_BITS-1:0];
          range_nxt    = range_w[SAMPLE_BITS-1:0];
          state_nxt    = ST_DONE;
          case (in_ch.action)
            ACT_ADD: begin
              if (!in_range_w) begin
                if (out_cnt_r != '1) begin
                  out_cnt_nxt = out_cnt_r + CNT_W'(1);
                end
              end else begin
                res_acc_nxt = 1'b1;
                // A saturated in-range count freezes the sum as well.
                if (in_cnt_r != '1) begin
                  in_cnt_nxt = in_cnt_r + CNT_W'(1);
                  sum_nxt    = sum_sat;
                end
                state_nxt = ST_BIN_START;
              end
            end
            ACT_READ: begin
              mem_req.rd_en = 1'b1;
              mem_req.addr  = in_ch.bin_index;
              state_nxt     = ST_READ_WAIT;
            end
            ACT_CLEAR: begin
              mem_req.clear = 1'b1;
              in_cnt_nxt    = '0;
              sum_nxt       = '0;
              mean_nxt      = '0;
            end
            default: ;
          endcase
        end
      end

      ST_BIN_START: begin
        if (range_r == '0) begin
          ix_nxt    = '0;
          state_nxt = ST_BIN_RD;
        end else begin
          div_req.start    = 1'b1;
          div_req.iters    = ITER_W'(PROD_W);
          div_req.dividend = {prod_w, {(DIV_W-PROD_W){1'b0}}};
          div_req.divisor  = DVS_W'(range_r);
          state_nxt        = ST_BIN_DIV;
        end
      end

      ST_BIN_DIV: begin
        if (div_rsp.done) begin
          ix_nxt    = quo_w[BINS_W-1:0];
          state_nxt = ST_BIN_RD;
        end
      end

      ST_BIN_RD: begin
        // With nonzero width, a sample on the high bound gets index = bin count.
        if (ix_r < nb_w) begin
          mem_req.rd_en = 1'b1;
          state_nxt     = ST_BIN_WR;
        end else begin
          state_nxt = ST_MEAN_START;
        end
      end

      ST_BIN_WR: begin
        mem_req.wr_en = 1'b1;
        res_hit_nxt   = ix_r;
        state_nxt     = ST_MEAN_START;
      end

      ST_MEAN_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_MEAN_DIV;
      end

      ST_MEAN_DIV: begin
        if (div_rsp.done) begin
          if (sum_r[SUM_W-1]) begin
            if (quo_w > DIV_W'(MEAN_MIN)) begin
              mean_nxt = MEAN_MIN;
            end else begin
              mean_nxt = MEAN_W'(0) - quo_w[MEAN_W-1:0];
            end
          end else begin
            if (quo_w > DIV_W'(MEAN_MAX)) begin
              mean_nxt = MEAN_MAX;
            end else begin
              mean_nxt = quo_w[MEAN_W-1:0];
            end
          end
          state_nxt = ST_DONE;
        end
      end

      ST_READ_WAIT: begin
        res_read_nxt = ({1'b0, rd_idx_r} < nb_w) ? mem_rd_data : '0;
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid                = out_vld_r;
  assign out_ch.sample_accepted      = out_acc_r;
  assign out_ch.bin_hit              = out_hit_r;
  assign out_ch.bin_count_value      = out_read_r;
  assign out_ch.samples_in_range     = out_in_cnt_r;
  assign out_ch.samples_out_of_range = out_out_cnt_r;
  assign out_ch.mean_value           = out_mean_r;

endmodule

// ----- design/rhm_checker.sv -----
// ----------------------------------------------------------------------------
// rhm_checker
// Port-level checks for the range histogram, bound to the top level.
// ----------------------------------------------------------------------------
module rhm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             sample_accepted,
  input logic [rhm_pkg::BINS_W-1:0]       bin_hit,
  input logic [rhm_pkg::CNT_W-1:0]        samples_in_range,
  input logic signed [rhm_pkg::MEAN_W-1:0] mean_value
);
  import rhm_pkg::*;

  // Only one request is worked at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(samples_in_range)
                                && $stable(mean_value))
    else $error("stalled result changed");

  a_reject_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sample_accepted |-> bin_hit == BINS_W'(NUM_BINS))
    else $error("bin reported without an accepted sample");

  a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_accepted |-> samples_in_range != '0)
    else $error("accepted sample left the in-range count at zero");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && samples_in_range == '0 |-> mean_value == '0)
    else $error("nonzero mean with no samples");

endmodule

bind range_histogram_with_mean rhm_checker u_rhm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .sample_accepted  (out_ch.sample_accepted),
  .bin_hit          (out_ch.bin_hit),
  .samples_in_range (out_ch.samples_in_range),
  .mean_value       (out_ch.mean_value)
);

// ----- tb/range_histogram_with_mean_check.sv -----
// ----------------------------------------------------------------------------
// range_histogram_with_mean_check
// Watches the request, result and register channels of the range histogram.
// It keeps its own copy of the bins, counters, sum and range registers. For
// each accepted request it computes the expected status. It compares every
// accepted result against the oldest pending status and reports mismatches.
// ----------------------------------------------------------------------------
module range_histogram_with_mean_check (
  input  logic clk,
  input  logic rst_n,
  rhm_in_if    in_ch,
  rhm_out_if   out_ch,
  rhm_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rhm_pkg::*;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam longint SUM_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam longint MEAN_HI = 64'sd8388607;
  localparam longint MEAN_LO = -64'sd8388608;

  typedef struct {
    logic              accepted;
    logic [BINS_W-1:0] hit;
    logic [CNT_W-1:0]  bin_value;
    logic [CNT_W-1:0]  in_range;
    logic [CNT_W-1:0]  out_range;
    logic [MEAN_W-1:0] mean;
  } status_t;

  logic signed [SAMPLE_BITS-1:0] low_q;
  logic signed [SAMPLE_BITS-1:0] high_q;
  logic [BINS_W-1:0]             bins_q;
  logic [CNT_W-1:0]              bin_count [NUM_BINS];
  logic [CNT_W-1:0]              in_count;
  logic [CNT_W-1:0]              out_count;
  longint                        sum_q;
  status_t                       pending_status [$];
  int                            error_count = 0;

  assign mismatches = error_count;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  function automatic void clear_histogram();
    foreach (bin_count[i]) bin_count[i] = '0;
    in_count = '0;
    sum_q = 0;
  endfunction

  function automatic logic [MEAN_W-1:0] running_mean();
    longint q;
    if (in_count == '0) return '0;
    q = (sum_q * 256) / longint'({32'b0, in_count});
    if (q > MEAN_HI) q = MEAN_HI;
    if (q < MEAN_LO) q = MEAN_LO;
    return q[MEAN_W-1:0];
  endfunction

  // Applies one request to the local histogram and returns the status it reports.
  function automatic status_t apply_request(logic [1:0] act,
                                            logic signed [SAMPLE_BITS-1:0] smp,
                                            logic [BIN_IDX_W-1:0] idx);
    status_t st;
    longint  s, lo, hi, span, slot, total;
    int      nb;
    nb = (bins_q == '0) ? 1 : ((bins_q > NUM_BINS) ? NUM_BINS : int'(bins_q));
    st.accepted  = 1'b0;
    st.hit       = BINS_W'(NUM_BINS);
    st.bin_value = '0;
    case (act)
      ACT_ADD: begin
        s  = smp;
        lo = low_q;
        hi = high_q;
        if (s < lo || s > hi) begin
          out_count = sat_inc(out_count);
        end else begin
          st.accepted = 1'b1;
          // Once the count is pinned, the sum freezes so the mean stays put.
          if (in_count != CNT_SAT) begin
            total = sum_q + s;
            if (total > SUM_HI) total = SUM_HI;
            if (total < SUM_LO) total = SUM_LO;
            sum_q = total;
            in_count = in_count + 1'b1;
          end
          span = hi - lo;
          slot = 0;
          if (span != 0) slot = ((s - lo) * nb) / span;
          // With span nonzero, a high-bound sample maps one past the last bin.
          if (slot < nb) begin
            bin_count[slot] = sat_inc(bin_count[slot]);
            st.hit = BINS_W'(slot);
          end
        end
      end
      ACT_READ: begin
        if (idx < nb) st.bin_value = bin_count[idx];
      end
      ACT_CLEAR: begin
        clear_histogram();
      end
      default: begin
      end
    endcase
    st.in_range  = in_count;
    st.out_range = out_count;
    st.mean      = running_mean();
    return st;
  endfunction

  task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      clear_histogram();
      out_count = '0;
      low_q     = '0;
      high_q    = '0;
      bins_q    = BINS_W'(1);
      pending_status.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_LOW_BOUND:  low_q  = cfg_ch.data;
          CFG_HIGH_BOUND: high_q = cfg_ch.data;
          CFG_BINS:       bins_q = cfg_ch.data[BINS_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_status.insert(pending_status.size(),
                              apply_request(in_ch.action, in_ch.sample, in_ch.bin_index));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          error_count++;
          $display("%0t: result arrived with no request pending", $time);
        end else begin
          want = pending_status.pop_front();
          compare_field("sample_accepted", CNT_W'(want.accepted), CNT_W'(out_ch.sample_accepted));
          compare_field("bin_hit", CNT_W'(want.hit), CNT_W'(out_ch.bin_hit));
          compare_field("bin_count_value", want.bin_value, out_ch.bin_count_value);
          compare_field("samples_in_range", want.in_range, out_ch.samples_in_range);
          compare_field("samples_out_of_range", want.out_range, out_ch.samples_out_of_range);
          compare_field("mean_value", CNT_W'(want.mean),
                        CNT_W'(out_ch.mean_value[MEAN_W-1:0]));
        end
      end
    end
    outstanding <= pending_status.size();
  end

endmodule

// ----- tb/range_histogram_with_mean_test.sv -----
// ----------------------------------------------------------------------------
// range_histogram_with_mean_test
// Drives the range histogram with directed corner requests, then random
// phases with random ranges and bin counts, under random idle and stall
// bursts. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module range_histogram_with_mean_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rhm_pkg::*;

  localparam logic [1:0]           ACT_UNKNOWN  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int                   RANDOM_ITEMS = 420;
  localparam int                   CALM_ITEMS   = 60;
  // Idle time run after the last result has come back.
  localparam int                   DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n;
  bit   gaps_on;
  int   stall_left = 0;
  int   mismatches;
  int   outstanding;
  int   adds_sent, reads_sent, clears_sent, unknown_sent, reg_writes;
  int   cur_lo, cur_hi, cur_eff;

  rhm_in_if  in_ch ();
  rhm_out_if out_ch ();
  rhm_cfg_if cfg_ch ();

  range_histogram_with_mean dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  range_histogram_with_mean_check hist_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stall bursts while gaps are enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int items_sent();
    return adds_sent + reads_sent + clears_sent + unknown_sent;
  endfunction

  task automatic send_request(logic [1:0] act, int smp, int idx);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.sample    <= SAMPLE_BITS'(smp);
    in_ch.bin_index <= BIN_IDX_W'(idx);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (act)
      ACT_ADD:   adds_sent++;
      ACT_READ:  reads_sent++;
      ACT_CLEAR: clears_sent++;
      default:   unknown_sent++;
    endcase
  endtask

  // Holds off new requests until every pending result has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic program_range(int lo, int hi, int bins_data, bit with_spare);
    logic [BINS_W-1:0] bins7;
    wait_idle();
    write_reg(CFG_LOW_BOUND, lo);
    write_reg(CFG_HIGH_BOUND, hi);
    if (with_spare) write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_BINS, bins_data);
    cfg_ch.valid <= 1'b0;
    bins7   = bins_data[BINS_W-1:0];
    cur_lo  = lo;
    cur_hi  = hi;
    cur_eff = (bins7 == '0) ? 1 : ((bins7 > NUM_BINS) ? NUM_BINS : int'(bins7));
  endtask

  function automatic int any_sample();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic random_setup();
    int lo, hi, swap;
    int bins_data;
    lo = any_sample();
    hi = any_sample();
    case ($urandom_range(0, 9))
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: hi = lo;
      2: begin
        lo = int'($urandom_range(0, 2000)) - 1000;
        hi = lo - int'($urandom_range(1, 2000));
      end
      3, 4: begin
        hi = lo + int'($urandom_range(0, 200));
        if (hi > 32767) hi = 32767;
      end
      default: begin
        if (hi < lo) begin
          swap = lo;
          lo = hi;
          hi = swap;
        end
      end
    endcase
    case ($urandom_range(0, 9))
      0:       bins_data = 0;
      1:       bins_data = $urandom_range(65, 127);
      2:       bins_data = $urandom_range(0, 65535);
      3:       bins_data = NUM_BINS;
      default: bins_data = $urandom_range(1, NUM_BINS);
    endcase
    program_range(lo, hi, bins_data, 1'b0);
  endtask

  task automatic random_item();
    int pick, smp, idx;
    pick = $urandom_range(0, 99);
    smp  = any_sample();
    idx  = $urandom_range(0, 63);
    if (pick < 72) begin
      if (cur_lo <= cur_hi && $urandom_range(0, 9) < 7) begin
        smp = cur_lo + int'($urandom_range(0, cur_hi - cur_lo));
      end else if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: smp = cur_lo;
          1: smp = cur_hi;
          2: smp = cur_lo - 1;
          3: smp = cur_hi + 1;
          4: smp = -32768;
          default: smp = 32767;
        endcase
      end
      send_request(ACT_ADD, smp, idx);
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, cur_eff - 1);
      send_request(ACT_READ, smp, idx);
    end else if (pick < 96) begin
      send_request(ACT_CLEAR, smp, idx);
    end else begin
      send_request(ACT_UNKNOWN, smp, idx);
    end
  endtask

  initial begin
    int target;
    rst_n            = 1'b0;
    gaps_on          = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_ADD;
    in_ch.sample     = '0;
    in_ch.bin_index  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_LOW_BOUND;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b1;
    cur_lo  = 0;
    cur_hi  = 0;
    cur_eff = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset range 0..0, one bin: zero width puts in-range samples in bin 0.
    send_request(ACT_ADD, 0, 0);
    send_request(ACT_ADD, 1, 63);
    send_request(ACT_ADD, -32768, 0);
    send_request(ACT_READ, 32767, 0);
    send_request(ACT_READ, 0, 63);
    send_request(ACT_UNKNOWN, -1, 21);
    send_request(ACT_CLEAR, 0, 0);

    program_range(-100, 100, NUM_BINS, 1'b0);
    send_request(ACT_ADD, -100, 0);
    send_request(ACT_ADD, 100, 0);
    send_request(ACT_ADD, 99, 0);
    send_request(ACT_ADD, 32767, 0);
    send_request(ACT_READ, 0, 63);
    send_request(ACT_READ, 0, 0);

    // Full range; a bins value of 127 behaves as 64.
    program_range(-32768, 32767, 16'hFFFF, 1'b0);
    send_request(ACT_ADD, -32768, 0);
    send_request(ACT_ADD, 32767, 0);
    send_request(ACT_ADD, -1, 0);
    send_request(ACT_READ, 0, 31);
    send_request(ACT_READ, 0, 32);

    // Zero bins acts as one.
    program_range(-10, 10, 0, 1'b0);
    send_request(ACT_ADD, -10, 0);
    send_request(ACT_ADD, 10, 0);
    send_request(ACT_READ, 0, 0);

    // Inverted range rejects everything; the histogram survives the writes.
    program_range(10, -10, 100, 1'b1);
    send_request(ACT_ADD, 0, 0);
    send_request(ACT_READ, 0, 0);
    send_request(ACT_CLEAR, 0, 0);

    target = items_sent() + RANDOM_ITEMS;
    while (items_sent() < target) begin
      random_setup();
      repeat ($urandom_range(20, 60)) begin
        if (items_sent() >= target) break;
        if (target - items_sent() <= CALM_ITEMS) gaps_on = 1'b0;
        random_item();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d adds, %0d reads, %0d clears and %0d unknown actions,",
             adds_sent, reads_sent, clears_sent, unknown_sent);
    $display("with %0d register writes across directed and random range settings.",
             reg_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
